FILE: src/ipbd_pkg.sv
// ----------------------------------------------------------------------------
// IO processor bus address decoder: shared package
// Span table, list membership, target and width codes, and the stage records
// that travel down the decode pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ipbd_pkg;

    // Access command and width codes.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] W_BYTE = 2'd0;
    localparam logic [1:0] W_HALF = 2'd1;
    localparam logic [1:0] W_WORD = 2'd2;
    localparam logic [1:0] W_BAD  = 2'd3;

    // Target codes.
    localparam logic [4:0] T_RAM       = 5'd0;
    localparam logic [4:0] T_BIOS      = 5'd1;
    localparam logic [4:0] T_SPAD      = 5'd2;
    localparam logic [4:0] T_INTC      = 5'd3;
    localparam logic [4:0] T_CDVD      = 5'd4;
    localparam logic [4:0] T_SIO2      = 5'd5;
    localparam logic [4:0] T_ROM1      = 5'd6;
    localparam logic [4:0] T_ROM2      = 5'd7;
    localparam logic [4:0] T_DEV9      = 5'd8;
    localparam logic [4:0] T_SPEED     = 5'd9;
    localparam logic [4:0] T_TIMERS    = 5'd10;
    localparam logic [4:0] T_DMA       = 5'd11;
    localparam logic [4:0] T_SPU2      = 5'd12;
    localparam logic [4:0] T_SIF       = 5'd13;
    localparam logic [4:0] T_USB       = 5'd14;
    localparam logic [4:0] T_FIREWIRE  = 5'd15;
    localparam logic [4:0] T_SBUS      = 5'd16;
    localparam logic [4:0] T_FIXED     = 5'd17;
    localparam logic [4:0] T_IGNORED   = 5'd18;
    localparam logic [4:0] T_UNHANDLED = 5'd19;

    // How the final stage forms the offset.
    localparam logic [1:0] OFF_ADDR = 2'd0;
    localparam logic [1:0] OFF_RAM  = 2'd1;
    localparam logic [1:0] OFF_BIOS = 2'd2;
    localparam logic [1:0] OFF_SPAN = 2'd3;

    // Address geometry.
    localparam int MASKED_BITS     = 29;
    localparam int BIOS_PAGES_LOG2 = 9;
    localparam int RAM_OFF_BITS    = 24;

    localparam logic [4:0]  RAM_LOG2_RESET = 5'd21;
    localparam logic [4:0]  RAM_LOG2_MAX   = 5'd24;
    localparam logic [RAM_OFF_BITS-1:0] RAM_MASK_RESET =
        RAM_OFF_BITS'((32'd1 << RAM_LOG2_RESET) - 32'd1);

    // Special addresses and fixed read values.
    localparam logic [31:0] BIU_ADDR        = 32'hfffe_0130;
    localparam logic [31:0] BIU_READ_VALUE  = 32'hffff_ffff;
    localparam logic [31:0] FIX8_ADDR       = 32'h1f80_3204;
    localparam logic [31:0] FIX8_VALUE      = 32'h0000_007c;
    localparam logic [31:0] FIX32_SBUS_ADDR = 32'h1f80_1450;
    localparam logic [31:0] FIX32_ONE_ADDR  = 32'h1f80_1414;
    localparam logic [31:0] FIX32_DMA_ADDR  = 32'h1f80_1560;
    localparam logic [31:0] FIX32_ONE_VALUE = 32'h0000_0001;
    localparam logic [7:0]  ROM_SEGMENT     = 8'h1e;

    // Device address spans. They are pairwise disjoint, so at most one hits.
    localparam int NUM_SPANS = 19;

    localparam int SP_SPAD  = 0;
    localparam int SP_INTC  = 1;
    localparam int SP_CDVD  = 2;
    localparam int SP_SIO2  = 3;
    localparam int SP_ROM1  = 4;
    localparam int SP_ROM2  = 5;
    localparam int SP_DEV9  = 6;
    localparam int SP_SPEED = 7;
    localparam int SP_TMR_A = 8;
    localparam int SP_TMR_B = 9;
    localparam int SP_DMA_A = 10;
    localparam int SP_DMA_B = 11;
    localparam int SP_DMA_C = 12;
    localparam int SP_DMA_D = 13;
    localparam int SP_SPU2  = 14;
    localparam int SP_SIF   = 15;
    localparam int SP_USB   = 16;
    localparam int SP_FW    = 17;
    localparam int SP_SBUS  = 18;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [4:0]  tgt;
        logic        mem;
    } t_span;

    localparam t_span SPANS [NUM_SPANS] = '{
        '{32'h1F80_0000, 32'h1F80_03FF, T_SPAD,     1'b1},
        '{32'h1F80_1070, 32'h1F80_107B, T_INTC,     1'b0},
        '{32'h1F40_2004, 32'h1F40_20FF, T_CDVD,     1'b0},
        '{32'h1F80_8200, 32'h1F80_8280, T_SIO2,     1'b0},
        '{32'h1E00_0000, 32'h1E3F_FFFF, T_ROM1,     1'b1},
        '{32'h1E40_0000, 32'h1E7F_FFFF, T_ROM2,     1'b1},
        '{32'h1F80_1460, 32'h1F80_147F, T_DEV9,     1'b0},
        '{32'h1000_0000, 32'h1000_FFFF, T_SPEED,    1'b0},
        '{32'h1F80_1100, 32'h1F80_112F, T_TIMERS,   1'b0},
        '{32'h1F80_1480, 32'h1F80_14AF, T_TIMERS,   1'b0},
        '{32'h1F80_1080, 32'h1F80_10EF, T_DMA,      1'b0},
        '{32'h1F80_1500, 32'h1F80_155F, T_DMA,      1'b0},
        '{32'h1F80_1570, 32'h1F80_157F, T_DMA,      1'b0},
        '{32'h1F80_10F0, 32'h1F80_10F8, T_DMA,      1'b0},
        '{32'h1F90_0000, 32'h1F90_07FF, T_SPU2,     1'b0},
        '{32'h1D00_0000, 32'h1D00_006F, T_SIF,      1'b0},
        '{32'h1F80_1600, 32'h1F80_16FF, T_USB,      1'b0},
        '{32'h1F80_8400, 32'h1F80_854F, T_FIREWIRE, 1'b0},
        '{32'h1F80_1450, 32'h1F80_1453, T_SBUS,     1'b0}
    };

    // Spans that the list for this command and width contains.
    function automatic logic [NUM_SPANS-1:0] list_mask(input logic cmd,
                                                       input logic [1:0] width);
        logic [NUM_SPANS-1:0] m;
        m = '0;
        case ({cmd, width})
            {CMD_READ, W_BYTE}: begin
                m[SP_SPAD] = 1'b1; m[SP_INTC] = 1'b1; m[SP_CDVD] = 1'b1;
                m[SP_SIO2] = 1'b1; m[SP_ROM1] = 1'b1; m[SP_ROM2] = 1'b1;
                m[SP_DEV9] = 1'b1; m[SP_SPEED] = 1'b1;
            end
            {CMD_READ, W_HALF}: begin
                m[SP_SPAD] = 1'b1; m[SP_INTC] = 1'b1; m[SP_TMR_A] = 1'b1;
                m[SP_TMR_B] = 1'b1; m[SP_DMA_A] = 1'b1; m[SP_DMA_B] = 1'b1;
                m[SP_DMA_C] = 1'b1; m[SP_DMA_D] = 1'b1; m[SP_SPU2] = 1'b1;
                m[SP_ROM1] = 1'b1; m[SP_ROM2] = 1'b1; m[SP_DEV9] = 1'b1;
                m[SP_SPEED] = 1'b1;
            end
            {CMD_READ, W_WORD}: begin
                m[SP_SPAD] = 1'b1; m[SP_SIF] = 1'b1; m[SP_INTC] = 1'b1;
                m[SP_DMA_A] = 1'b1; m[SP_DMA_B] = 1'b1; m[SP_DMA_C] = 1'b1;
                m[SP_DMA_D] = 1'b1; m[SP_TMR_A] = 1'b1; m[SP_TMR_B] = 1'b1;
                m[SP_SIO2] = 1'b1; m[SP_USB] = 1'b1; m[SP_FW] = 1'b1;
                m[SP_ROM1] = 1'b1; m[SP_ROM2] = 1'b1; m[SP_DEV9] = 1'b1;
                m[SP_SPEED] = 1'b1;
            end
            {CMD_WRITE, W_BYTE}: begin
                m[SP_SPAD] = 1'b1; m[SP_CDVD] = 1'b1; m[SP_INTC] = 1'b1;
                m[SP_DMA_A] = 1'b1; m[SP_DMA_B] = 1'b1; m[SP_DMA_C] = 1'b1;
                m[SP_DMA_D] = 1'b1; m[SP_SIO2] = 1'b1; m[SP_DEV9] = 1'b1;
                m[SP_SPEED] = 1'b1;
            end
            {CMD_WRITE, W_HALF}: begin
                m[SP_SPAD] = 1'b1; m[SP_TMR_A] = 1'b1; m[SP_TMR_B] = 1'b1;
                m[SP_INTC] = 1'b1; m[SP_DMA_A] = 1'b1; m[SP_DMA_B] = 1'b1;
                m[SP_DMA_C] = 1'b1; m[SP_DMA_D] = 1'b1; m[SP_SPU2] = 1'b1;
                m[SP_DEV9] = 1'b1; m[SP_SPEED] = 1'b1;
            end
            {CMD_WRITE, W_WORD}: begin
                m[SP_SPAD] = 1'b1; m[SP_SIF] = 1'b1; m[SP_SBUS] = 1'b1;
                m[SP_INTC] = 1'b1; m[SP_DMA_A] = 1'b1; m[SP_DMA_B] = 1'b1;
                m[SP_DMA_C] = 1'b1; m[SP_DMA_D] = 1'b1; m[SP_TMR_A] = 1'b1;
                m[SP_TMR_B] = 1'b1; m[SP_SIO2] = 1'b1; m[SP_USB] = 1'b1;
                m[SP_FW] = 1'b1; m[SP_DEV9] = 1'b1; m[SP_SPEED] = 1'b1;
            end
            default: m = '0;
        endcase
        return m;
    endfunction

    // Width used toward a span's device. Timers take halfword accesses as
    // words, and DMA takes byte writes as words.
    function automatic logic [1:0] span_dw(input logic cmd, input logic [1:0] width,
                                           input int idx);
        logic is_tmr;
        logic is_dma;
        is_tmr = (idx == SP_TMR_A) || (idx == SP_TMR_B);
        is_dma = (idx == SP_DMA_A) || (idx == SP_DMA_B) ||
                 (idx == SP_DMA_C) || (idx == SP_DMA_D);
        if (width == W_HALF && is_tmr) begin
            return W_WORD;
        end
        if (cmd == CMD_WRITE && width == W_BYTE && is_dma) begin
            return W_WORD;
        end
        return width;
    endfunction

    // Record after the compare stage.
    typedef struct packed {
        logic                 cmd;
        logic [1:0]           width;
        logic [31:0]          addr;
        logic [31:0]          wdata;
        logic [NUM_SPANS-1:0] hit;
        logic                 biu;
        logic                 ram;
        logic                 bios;
        logic                 fix8;
        logic                 fix32;
        logic                 fix32_one;
    } t_s1;

    // Record after the select stage.
    typedef struct packed {
        logic [4:0]  tgt;
        logic [1:0]  dw;
        logic [1:0]  off_sel;
        logic [31:0] lo;
        logic [31:0] addr;
        logic [31:0] fixv;
        logic [31:0] fwd;
    } t_s2;

endpackage

`default_nettype wire

FILE: src/ipbd_match.sv
// ----------------------------------------------------------------------------
// IO processor bus address decoder: compare stage
// Runs every span compare and fast-path check in parallel and registers the
// hit flags with the access.
// ----------------------------------------------------------------------------
`default_nettype none

module ipbd_match #(
    parameter int PAGE_BITS        = 13,
    parameter int RAM_WINDOW_BYTES = 16777216
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_cmd,
    input  wire logic [1:0]        i_width,
    input  wire logic [31:0]       i_addr,
    input  wire logic [31:0]       i_wdata,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ipbd_pkg::t_s1          o_s1
);

    localparam int MB = ipbd_pkg::MASKED_BITS;
    localparam logic [MB-1:0] RAM_LIMIT =
        MB'((64'(RAM_WINDOW_BYTES) >> PAGE_BITS) << PAGE_BITS);
    localparam logic [MB-1:0] BIOS_BASE =
        MB'(((64'd1 << (MB - PAGE_BITS)) - (64'd1 << ipbd_pkg::BIOS_PAGES_LOG2))
            << PAGE_BITS);

    logic          r_valid;
    ipbd_pkg::t_s1 r_s1;
    ipbd_pkg::t_s1 n_s1;
    logic [MB-1:0] masked;

    assign o_ready = !r_valid || i_ready;
    assign masked  = i_addr[MB-1:0];

    always_comb begin
        n_s1.cmd   = i_cmd;
        n_s1.width = i_width;
        n_s1.addr  = i_addr;
        n_s1.wdata = i_wdata;
        for (int i = 0; i < ipbd_pkg::NUM_SPANS; i++) begin
            n_s1.hit[i] = (i_addr >= ipbd_pkg::SPANS[i].lo) &&
                          (i_addr <= ipbd_pkg::SPANS[i].hi);
        end
        n_s1.biu       = (i_addr == ipbd_pkg::BIU_ADDR);
        n_s1.ram       = (masked < RAM_LIMIT);
        n_s1.bios      = (masked >= BIOS_BASE);
        n_s1.fix8      = (i_addr == ipbd_pkg::FIX8_ADDR);
        n_s1.fix32_one = (i_addr == ipbd_pkg::FIX32_ONE_ADDR);
        n_s1.fix32     = (i_addr == ipbd_pkg::FIX32_SBUS_ADDR) ||
                         (i_addr == ipbd_pkg::FIX32_ONE_ADDR) ||
                         (i_addr == ipbd_pkg::FIX32_DMA_ADDR) ||
                         (i_addr[31:24] == ipbd_pkg::ROM_SEGMENT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

`default_nettype wire

FILE: src/ipbd_select.sv
// ----------------------------------------------------------------------------
// IO processor bus address decoder: select stage
// Applies the decode priority, picks the span of the access's list and
// settles target, device width, fixed value and forwarded data.
// ----------------------------------------------------------------------------
`default_nettype none

module ipbd_select (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire ipbd_pkg::t_s1     i_s1,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ipbd_pkg::t_s2          o_s2
);

    logic                           r_valid;
    ipbd_pkg::t_s2                  r_s2;
    ipbd_pkg::t_s2                  n_s2;
    logic [ipbd_pkg::NUM_SPANS-1:0] sel_hit;
    logic [4:0]                     span_tgt;
    logic [1:0]                     span_dw;
    logic [31:0]                    span_lo;
    logic                           span_mem;
    logic                           is_wr;
    logic                           fix_hit;
    logic [31:0]                    fix_val;
    logic [31:0]                    wr_data;

    assign o_ready = !r_valid || i_ready;

    // The spans are disjoint, so an OR over the selected hits is the match.
    always_comb begin
        sel_hit  = i_s1.hit & ipbd_pkg::list_mask(i_s1.cmd, i_s1.width);
        span_tgt = '0;
        span_dw  = '0;
        span_lo  = '0;
        span_mem = 1'b0;
        for (int i = 0; i < ipbd_pkg::NUM_SPANS; i++) begin
            if (sel_hit[i]) begin
                span_tgt = span_tgt | ipbd_pkg::SPANS[i].tgt;
                span_dw  = span_dw | ipbd_pkg::span_dw(i_s1.cmd, i_s1.width, i);
                span_lo  = span_lo | ipbd_pkg::SPANS[i].lo;
                span_mem = span_mem | ipbd_pkg::SPANS[i].mem;
            end
        end
    end

    always_comb begin
        is_wr   = (i_s1.cmd == ipbd_pkg::CMD_WRITE);
        wr_data = is_wr ? i_s1.wdata : '0;
        fix_hit = ((i_s1.width == ipbd_pkg::W_BYTE) && i_s1.fix8) ||
                  ((i_s1.width == ipbd_pkg::W_WORD) && i_s1.fix32);
        if (i_s1.width == ipbd_pkg::W_BYTE) begin
            fix_val = ipbd_pkg::FIX8_VALUE;
        end else if (i_s1.fix32_one) begin
            fix_val = ipbd_pkg::FIX32_ONE_VALUE;
        end else begin
            fix_val = '0;
        end

        n_s2.tgt     = ipbd_pkg::T_UNHANDLED;
        n_s2.dw      = i_s1.width;
        n_s2.off_sel = ipbd_pkg::OFF_ADDR;
        n_s2.lo      = span_lo;
        n_s2.addr    = i_s1.addr;
        n_s2.fixv    = '0;
        n_s2.fwd     = '0;

        if (i_s1.width == ipbd_pkg::W_BAD) begin
            n_s2.dw = ipbd_pkg::W_BYTE;
        end else if (!is_wr && i_s1.width == ipbd_pkg::W_WORD && i_s1.biu) begin
            // The bus interface control word reads as all ones.
            n_s2.tgt  = ipbd_pkg::T_FIXED;
            n_s2.fixv = ipbd_pkg::BIU_READ_VALUE;
        end else if (i_s1.ram) begin
            n_s2.tgt     = ipbd_pkg::T_RAM;
            n_s2.off_sel = ipbd_pkg::OFF_RAM;
            n_s2.fwd     = wr_data;
        end else if (!is_wr && i_s1.bios) begin
            n_s2.tgt     = ipbd_pkg::T_BIOS;
            n_s2.off_sel = ipbd_pkg::OFF_BIOS;
        end else if (is_wr && i_s1.width == ipbd_pkg::W_WORD && i_s1.biu) begin
            n_s2.tgt = ipbd_pkg::T_IGNORED;
        end else if (|sel_hit) begin
            n_s2.tgt     = span_tgt;
            n_s2.dw      = span_dw;
            n_s2.off_sel = span_mem ? ipbd_pkg::OFF_SPAN : ipbd_pkg::OFF_ADDR;
            n_s2.fwd     = wr_data;
        end else if (!is_wr && fix_hit) begin
            n_s2.tgt  = ipbd_pkg::T_FIXED;
            n_s2.fixv = fix_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

`default_nettype wire

FILE: src/ipbd_offset.sv
// ----------------------------------------------------------------------------
// IO processor bus address decoder: offset stage
// Forms the target offset (RAM mirror mask, BIOS window, span-relative
// subtract or full address) and holds the result beat for the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module ipbd_offset #(
    parameter int PAGE_BITS = 13
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire ipbd_pkg::t_s2                     i_s2,
    input  wire logic [ipbd_pkg::RAM_OFF_BITS-1:0] i_ram_mask,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [4:0]                             o_tgt,
    output logic [1:0]                             o_dw,
    output logic [31:0]                            o_off,
    output logic [31:0]                            o_fixv,
    output logic [31:0]                            o_fwd
);

    localparam int RB = ipbd_pkg::RAM_OFF_BITS;
    localparam logic [31:0] BIOS_OFF_MASK =
        32'((64'd1 << (PAGE_BITS + ipbd_pkg::BIOS_PAGES_LOG2)) - 64'd1);

    logic        r_valid;
    logic [4:0]  r_tgt;
    logic [1:0]  r_dw;
    logic [31:0] r_off;
    logic [31:0] r_fixv;
    logic [31:0] r_fwd;
    logic [31:0] n_off;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        case (i_s2.off_sel)
            ipbd_pkg::OFF_RAM:  n_off = {{(32 - RB){1'b0}}, i_s2.addr[RB-1:0] & i_ram_mask};
            ipbd_pkg::OFF_BIOS: n_off = i_s2.addr & BIOS_OFF_MASK;
            ipbd_pkg::OFF_SPAN: n_off = i_s2.addr - i_s2.lo;
            default:            n_off = i_s2.addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tgt  <= i_s2.tgt;
            r_dw   <= i_s2.dw;
            r_off  <= n_off;
            r_fixv <= i_s2.fixv;
            r_fwd  <= i_s2.fwd;
        end
    end

    assign o_valid = r_valid;
    assign o_tgt   = r_tgt;
    assign o_dw    = r_dw;
    assign o_off   = r_off;
    assign o_fixv  = r_fixv;
    assign o_fwd   = r_fwd;

endmodule

`default_nettype wire

FILE: src/io_processor_bus_address_decoder.sv
// ----------------------------------------------------------------------------
// IO processor bus address decoder
// Decodes one bus access per beat into a target device, offset, device width,
// fixed read value and forwarded write data.
// ----------------------------------------------------------------------------
// Each slave beat carries one access (read or write, byte/halfword/word,
// address, write data); each master beat carries its decode. The decoder
// takes one beat per cycle unless the master side stalls: a compare stage
// runs every span compare and fast-path check in parallel, a select stage
// applies the decode priority and picks the span of the access's list, and an
// offset stage forms the offset (one 32-bit subtract) and holds the result
// beat. Each stage has its own valid bit and takes a new beat whenever it is
// empty or its contents move on, so bubbles are squeezed out during a stall
// and nothing is dropped or repeated. The low 29 address bits select the
// page: pages inside the RAM window go to main RAM, mirrored by the
// configured RAM size, and on reads the top 512 pages go to BIOS. All other
// accesses are matched on the full 32-bit address, so upper-segment aliases
// of device registers come back unhandled. The RAM size register is taken
// through its own write channel, clamped to the page size at the low end and
// 16 MB at the high end, and must only be written while the decoder is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module io_processor_bus_address_decoder #(
    parameter int PAGE_BITS        = 13,
    parameter int RAM_WINDOW_BYTES = 16777216
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Access beats.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // address[31:0], write_data[63:32]
    input  wire logic [7:0]  s_axis_tuser,   // cmd[0], access_width[2:1], zero[7:3]

    // Decode beats.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // target_offset[31:0],
                                             // fixed_read_value[63:32],
                                             // forward_data[95:64]
    output logic [7:0]       m_axis_tuser,   // target[4:0], device_width[6:5], zero[7]

    // RAM size register (log2 of installed bytes).
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_data
);

    localparam int RB = ipbd_pkg::RAM_OFF_BITS;
    localparam logic [4:0] LOG2_MIN = 5'(PAGE_BITS);

    logic          s1_valid;
    logic          s1_ready;
    ipbd_pkg::t_s1 s1;
    logic          s2_valid;
    logic          s2_ready;
    ipbd_pkg::t_s2 s2;

    logic [4:0]    o_tgt;
    logic [1:0]    o_dw;
    logic [31:0]   o_off;
    logic [31:0]   o_fixv;
    logic [31:0]   o_fwd;

    // The mirror mask is kept ready-made so the offset stage only ANDs.
    logic [RB-1:0] r_ram_mask;
    logic [RB-1:0] n_ram_mask;
    logic [4:0]    cfg_log2;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data < LOG2_MIN) begin
            cfg_log2 = LOG2_MIN;
        end else if (i_cfg_data > ipbd_pkg::RAM_LOG2_MAX) begin
            cfg_log2 = ipbd_pkg::RAM_LOG2_MAX;
        end else begin
            cfg_log2 = i_cfg_data;
        end
        for (int b = 0; b < RB; b++) begin
            n_ram_mask[b] = (5'(b) < cfg_log2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_mask <= ipbd_pkg::RAM_MASK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ram_mask <= n_ram_mask;
        end
    end

    ipbd_match #(
        .PAGE_BITS        (PAGE_BITS),
        .RAM_WINDOW_BYTES (RAM_WINDOW_BYTES)
    ) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser[0]),
        .i_width (s_axis_tuser[2:1]),
        .i_addr  (s_axis_tdata[31:0]),
        .i_wdata (s_axis_tdata[63:32]),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_s1    (s1)
    );

    ipbd_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_s2    (s2)
    );

    ipbd_offset #(
        .PAGE_BITS (PAGE_BITS)
    ) u_offset (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s2_valid),
        .o_ready    (s2_ready),
        .i_s2       (s2),
        .i_ram_mask (r_ram_mask),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_tgt      (o_tgt),
        .o_dw       (o_dw),
        .o_off      (o_off),
        .o_fixv     (o_fixv),
        .o_fwd      (o_fwd)
    );

    assign m_axis_tdata = {o_fwd, o_fixv, o_off};
    assign m_axis_tuser = {1'b0, o_dw, o_tgt};

endmodule

`default_nettype wire
